// ===== rtl/fwfs_pkg.sv =====
package fwfs_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned DataW = 8;
  localparam int unsigned OpW   = 2;
  localparam int unsigned StW   = 2;
  localparam int unsigned FillW = 5;
  localparam int unsigned ReadW = 32;
  localparam int unsigned SumW  = 48;

  typedef enum logic [OpW-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic [FillW-1:0] max_fill;
    logic [ReadW-1:0] read_total;
    logic [SumW-1:0]  fill_sum;
  } stats_t;

endpackage

// ===== rtl/fwfs_if.sv =====
interface fwfs_in_if import fwfs_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   operation;
  logic [DataW-1:0] write_data;

  modport source (output valid, output operation, output write_data, input ready);
  modport sink   (input valid, input operation, input write_data, output ready);
endinterface

interface fwfs_out_if import fwfs_pkg::*;;
  logic             valid;
  logic             ready;
  logic [DataW-1:0] read_data;
  logic [StW-1:0]   status;
  logic [FillW-1:0] fill_level;
  logic [FillW-1:0] max_fill;
  logic [ReadW-1:0] read_total;
  logic [SumW-1:0]  fill_sum;

  modport source (output valid, output read_data, output status, output fill_level,
                  output max_fill, output read_total, output fill_sum, input ready);
  modport sink   (input valid, input read_data, input status, input fill_level,
                  input max_fill, input read_total, input fill_sum, output ready);
endinterface

// ===== rtl/fwfs_cell.sv =====
module fwfs_cell import fwfs_pkg::*; (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [DataW-1:0] next_data_i,
  input  logic [DataW-1:0] write_data_i,
  output logic [DataW-1:0] data_o
);

  logic [DataW-1:0] data_q;
  logic [DataW-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift) begin
      data_d = next_data_i;
    end else if (ctrl_i.load) begin
      data_d = write_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/fwfs_stats.sv =====
module fwfs_stats import fwfs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            sample_i,
  input  logic [CntW-1:0] level_i,
  output stats_t          stats_o
);

  logic [FillW-1:0] peak_q, peak_d;
  logic [ReadW-1:0] reads_q, reads_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [SumW:0]    sum_ext;

  assign sum_ext = {1'b0, sum_q} + {{(SumW + 1 - CntW){1'b0}}, level_i};

  always_comb begin
    peak_d  = peak_q;
    reads_d = reads_q;
    sum_d   = sum_q;
    if (sample_i) begin
      // saturate on carry out
      sum_d = sum_ext[SumW] ? {SumW{1'b1}} : sum_ext[SumW-1:0];
      if (FillW'(level_i) > peak_q) begin
        peak_d = FillW'(level_i);
      end
      if (reads_q != {ReadW{1'b1}}) begin
        reads_d = reads_q + ReadW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q  <= '0;
      reads_q <= '0;
      sum_q   <= '0;
    end else begin
      peak_q  <= peak_d;
      reads_q <= reads_d;
      sum_q   <= sum_d;
    end
  end

  assign stats_o.max_fill   = peak_q;
  assign stats_o.read_total = reads_q;
  assign stats_o.fill_sum   = sum_q;

endmodule

// ===== rtl/fifo_with_fill_statistics.sv =====
// Byte FIFO with fill statistics.
// in_i carries one command per word: write (enqueue write_data), read
// (dequeue from the head) or clear (empty the queue, statistics kept).
// Code 3 is ignored. out_o carries exactly one result word per command:
// dequeued byte, status (done, full, empty), fill level after the command,
// peak fill seen at reads, saturating read count and saturating sum of the
// fill levels sampled at reads.
// Storage is a row of shift cells: a read moves every byte one cell toward
// the head, a write loads the cell right after the last occupied one.
// The result is registered and valid in the cycle after acceptance; one
// command is taken every cycle while the receiver keeps up.
// When the receiver stalls, the result register holds and in_i.ready drops
// until the result is taken; a new command is then accepted in the same
// cycle the result leaves.
// Reset empties the queue and clears all statistics; cell contents are
// not cleared, the fill count keeps reads on written cells.
module fifo_with_fill_statistics import fwfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  fwfs_in_if.sink    in_i,
  fwfs_out_if.source out_o
);

  logic [DataW-1:0] cell_data [Depth];
  cell_ctrl_t       cell_ctrl [Depth];
  stats_t           stats;

  logic [CntW-1:0]  count_q, count_d;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] read_data_q, read_data_d;
  status_e          status_q, status_d;

  logic accept;
  logic is_full;
  logic is_empty;
  logic do_write;
  logic do_read;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign is_full    = (count_q == CntW'(Depth));
  assign is_empty   = (count_q == '0);
  assign do_write   = accept && (in_i.operation == OP_WRITE) && !is_full;
  assign do_read    = accept && (in_i.operation == OP_READ) && !is_empty;

  for (genvar k = 0; k < Depth; k++) begin : g_cell
    logic [DataW-1:0] next_data;

    if (k == Depth - 1) begin : g_tail
      assign next_data = '0;
    end else begin : g_mid
      assign next_data = cell_data[k+1];
    end

    assign cell_ctrl[k].shift = do_read;
    assign cell_ctrl[k].load  = do_write && (count_q == CntW'(k));

    fwfs_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl[k]),
      .next_data_i  (next_data),
      .write_data_i (in_i.write_data),
      .data_o       (cell_data[k])
    );
  end

  fwfs_stats u_stats (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (do_read),
    .level_i  (count_q),
    .stats_o  (stats)
  );

  always_comb begin
    count_d     = count_q;
    read_data_d = read_data_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d = 1'b1;
      read_data_d = '0;
      status_d    = ST_DONE;
      unique case (in_i.operation)
        OP_WRITE: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            count_d = count_q + CntW'(1);
          end
        end
        OP_READ: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            read_data_d = cell_data[0];
            count_d     = count_q - CntW'(1);
          end
        end
        OP_CLEAR: begin
          count_d = '0;
        end
        default: begin
          // unused code: no state change
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    read_data_q <= read_data_d;
    status_q    <= status_d;
  end

  // stats and fill count only move when a command is taken, which happens
  // only when the result slot frees, so they match the held result
  assign out_o.valid      = out_valid_q;
  assign out_o.read_data  = read_data_q;
  assign out_o.status     = status_q;
  assign out_o.fill_level = FillW'(count_q);
  assign out_o.max_fill   = stats.max_fill;
  assign out_o.read_total = stats.read_total;
  assign out_o.fill_sum   = stats.fill_sum;

endmodule

// ===== sim/tb_fifo_with_fill_statistics.sv =====
module tb_fifo_with_fill_statistics;
  timeunit 1ns;
  timeprecision 1ps;

  import fwfs_pkg::*;

  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam int unsigned RandomWords = 1500;
  localparam int unsigned IdxW = $clog2(Depth);
  localparam logic [ReadW-1:0] ReadsMax = {ReadW{1'b1}};
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [DataW-1:0] data;
  } command_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic [StW-1:0]   status;
    logic [FillW-1:0] fill_level;
    logic [FillW-1:0] max_fill;
    logic [ReadW-1:0] read_total;
    logic [SumW-1:0]  fill_sum;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  fwfs_in_if  in_bus ();
  fwfs_out_if out_bus ();

  fifo_with_fill_statistics dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // shadow copy of the queue and its statistics
  logic [DataW-1:0] ring_bytes [Depth];
  logic [IdxW-1:0]  ring_head = '0;
  logic [FillW-1:0] ring_count = '0;
  logic [FillW-1:0] peak_seen = '0;
  logic [ReadW-1:0] reads_counted = '0;
  logic [SumW-1:0]  level_total = '0;

  command_t    command_queue [$];
  result_t     awaited_results [$];
  int unsigned accepted_words = 0;
  int unsigned total_words;
  int unsigned mismatch_count = 0;

  command_t    next_word;
  int unsigned burst_left = 0;
  int unsigned idle_left = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned stall_tick = 0;
  result_t     seen_word;
  result_t     wanted_word;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void apply_command(logic [OpW-1:0] op, logic [DataW-1:0] data);
    result_t r;
    r = '0;
    r.status = ST_DONE;
    if (op == OP_WRITE) begin
      if (ring_count >= FillW'(Depth)) begin
        r.status = ST_FULL;
      end else begin
        ring_bytes[ring_head + IdxW'(ring_count)] = data;
        ring_count++;
      end
    end else if (op == OP_READ) begin
      if (ring_count == '0) begin
        r.status = ST_EMPTY;
      end else begin
        // sample the level before the byte leaves
        if (SumMax - level_total < SumW'(ring_count)) level_total = SumMax;
        else level_total = level_total + SumW'(ring_count);
        if (ring_count > peak_seen) peak_seen = ring_count;
        if (reads_counted != ReadsMax) reads_counted++;
        r.read_data = ring_bytes[ring_head];
        ring_count--;
        ring_head++;
      end
    end else if (op == OP_CLEAR) begin
      ring_head  = '0;
      ring_count = '0;
    end
    r.fill_level = ring_count;
    r.max_fill   = peak_seen;
    r.read_total = reads_counted;
    r.fill_sum   = level_total;
    awaited_results.push_back(r);
  endfunction

  function automatic void add_command(logic [OpW-1:0] op, logic [DataW-1:0] data);
    command_t c;
    c.op   = op;
    c.data = data;
    command_queue.push_back(c);
  endfunction

  // driver: bursts of words separated by random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        apply_command(in_bus.operation, in_bus.write_data);
        accepted_words++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (idle_left > 0 || command_queue.size() == 0) begin
          if (idle_left > 0) idle_left--;
          in_bus.valid <= 1'b0;
        end else begin
          next_word = command_queue.pop_front();
          in_bus.valid      <= 1'b1;
          in_bus.operation  <= next_word.op;
          in_bus.write_data <= next_word.data;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 31);
            case ($urandom_range(0, 9))
              0, 1, 2, 3: idle_left = 0;
              4, 5, 6, 7: idle_left = $urandom_range(1, 3);
              default:    idle_left = $urandom_range(4, 12);
            endcase
          end
        end
      end
    end
  end

  // monitor: check each result word, stall in changing patterns
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        seen_word.read_data  = out_bus.read_data;
        seen_word.status     = out_bus.status;
        seen_word.fill_level = out_bus.fill_level;
        seen_word.max_fill   = out_bus.max_fill;
        seen_word.read_total = out_bus.read_total;
        seen_word.fill_sum   = out_bus.fill_sum;
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result word with none awaited: data=%h status=%0d fill=%0d",
                     $realtime, seen_word.read_data, seen_word.status, seen_word.fill_level);
        end else begin
          wanted_word = awaited_results.pop_front();
          if (seen_word.read_data !== wanted_word.read_data ||
              seen_word.status !== wanted_word.status ||
              seen_word.fill_level !== wanted_word.fill_level ||
              seen_word.max_fill !== wanted_word.max_fill ||
              seen_word.read_total !== wanted_word.read_total ||
              seen_word.fill_sum !== wanted_word.fill_sum) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: mismatch exp data=%h status=%0d fill=%0d max=%0d reads=%0d sum=%0d",
                       $realtime, wanted_word.read_data, wanted_word.status,
                       wanted_word.fill_level, wanted_word.max_fill,
                       wanted_word.read_total, wanted_word.fill_sum);
              $display("%0t:          got data=%h status=%0d fill=%0d max=%0d reads=%0d sum=%0d",
                       $realtime, seen_word.read_data, seen_word.status,
                       seen_word.fill_level, seen_word.max_fill,
                       seen_word.read_total, seen_word.fill_sum);
            end
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      stall_tick++;
      case (stall_mode)
        0:       out_bus.ready <= 1'b1;
        1:       out_bus.ready <= ($urandom_range(0, 3) != 0);
        default: out_bus.ready <= ((stall_tick % 5) >= 2);
      endcase
    end
  end

  initial begin
    logic [OpW-1:0] op;
    int unsigned    counted;
    int unsigned    run_len;
    int unsigned    bias;
    int unsigned    pick;

    rst_ni = 1'b0;

    // empty queue: refused read, clear and unused code
    add_command(OP_READ, 8'hFF);
    add_command(OP_CLEAR, 8'h00);
    add_command(OpUnused, 8'hFF);
    // fill to the top, then push once more
    add_command(OP_WRITE, 8'h00);
    add_command(OP_WRITE, 8'hFF);
    add_command(OP_WRITE, 8'h55);
    add_command(OP_WRITE, 8'hAA);
    for (int i = 4; i < Depth; i++) add_command(OP_WRITE, DataW'($urandom_range(0, 255)));
    add_command(OP_WRITE, 8'hFF);
    add_command(OpUnused, 8'h00);
    add_command(OP_READ, 8'h00);
    add_command(OP_READ, 8'hFF);
    add_command(OP_CLEAR, 8'hFF);
    add_command(OP_READ, 8'h00);
    add_command(OP_WRITE, 8'h81);
    add_command(OP_READ, 8'h00);

    // runs biased toward filling, draining or neither
    counted = 0;
    while (counted < RandomWords) begin
      run_len = $urandom_range(8, 64);
      bias = $urandom_range(0, 2);
      for (int k = 0; k < run_len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) op = OP_CLEAR;
        else if (pick < 4) op = OpUnused;
        else if (bias == 0) op = (pick < 75) ? OP_WRITE : OP_READ;
        else if (bias == 1) op = (pick < 25) ? OP_WRITE : OP_READ;
        else op = (pick < 52) ? OP_WRITE : OP_READ;
        add_command(op, DataW'($urandom_range(0, 255)));
        if (op != OpUnused) counted++;
      end
    end
    total_words = command_queue.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_words < total_words || awaited_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("** fifo_with_fill_statistics: PASSED **");
    end else begin
      $display("** fifo_with_fill_statistics: FAILED **");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("** fifo_with_fill_statistics: FAILED **");
    $finish;
  end

endmodule
